// ===== rtl/tick_to_millisecond_time_base_macros.svh =====
// Assertion macros for the millisecond time base.
// Each macro checks on the rising edge of clock and is disabled while reset is high.
`ifndef TICK_TO_MILLISECOND_TIME_BASE_MACROS_SVH
`define TICK_TO_MILLISECOND_TIME_BASE_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define TTMS_ASSERT_IMPLY(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("time base assertion failed");
// Next-cycle implication.
`define TTMS_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("time base assertion failed");
`else
`define TTMS_ASSERT_IMPLY(name, pre, post)
`define TTMS_ASSERT_NEXT(name, pre, post)
`endif

`endif

// ===== rtl/ttms_pkg.sv =====
package ttms_pkg;

   // default width of the sampled tick counter
   localparam int COUNTER_BITS_DEFAULT = 24;

   // conversion constants
   localparam int MS_PER_SECOND = 1000;
   localparam int DIV_BITS      = 16;
   localparam int CARRY_BITS    = 15;
   localparam logic [DIV_BITS-1:0] DIVISOR_MAX = 16'd32768;
   localparam logic [DIV_BITS-1:0] TPS_RESET   = 16'd32768;

   // time width and request kinds
   localparam int TIME_BITS = 64;
   localparam logic REQ_START  = 1'b0;
   localparam logic REQ_UPDATE = 1'b1;

   // sequencer states, one-hot
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_MUL_A = 7'b0000010,
      ST_MUL_B = 7'b0000100,
      ST_MUL_C = 7'b0001000,
      ST_DIV   = 7'b0010000,
      ST_ACC   = 7'b0100000,
      ST_SEND  = 7'b1000000
   } state_type;

endpackage

// ===== rtl/tick_to_millisecond_time_base.sv =====
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   req_type, req_counter_sample
// rsp_      out        rsp_valid/rsp_stall   rsp_time_ms
// csr_      in         csr_valid/csr_ready   csr_ticks_per_second
//
// A start transaction goes straight from idle to the send state. An update
// steps through MUL_A, MUL_B, MUL_C, the restoring divider, ACC and SEND;
// the divider produces one quotient bit per cycle over COUNTER_BITS + 11 bits.
// Reset (synchronous) clears the time, reference sample and carry, and loads
// ticks_per_second with 32768. req_stall is high while a transaction is being
// worked; a new one is taken while the previous result still waits on rsp_stall.
module tick_to_millisecond_time_base #(
   parameter int COUNTER_BITS = ttms_pkg::COUNTER_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_type,
   input  logic [COUNTER_BITS-1:0]            req_counter_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [ttms_pkg::TIME_BITS-1:0]     rsp_time_ms,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ttms_pkg::DIV_BITS-1:0]      csr_ticks_per_second
);

`include "tick_to_millisecond_time_base_macros.svh"

   // dividend holds delta * 1000 + carry
   localparam int TOTAL_BITS = COUNTER_BITS + 11;
   localparam int CNT_BITS   = $clog2(TOTAL_BITS);
   localparam int DB         = ttms_pkg::DIV_BITS;
   localparam int CB         = ttms_pkg::CARRY_BITS;
   localparam int TB         = ttms_pkg::TIME_BITS;

   ttms_pkg::state_type state_ff, state_in;

   logic [DB-1:0]           tps_ff, tps_in;
   logic [TB-1:0]           elapsed_ff, elapsed_in;
   logic [COUNTER_BITS-1:0] last_ff, last_in;
   logic [COUNTER_BITS-1:0] delta_ff, delta_in;
   logic [CB-1:0]           carry_ff, carry_in;
   logic [TOTAL_BITS-1:0]   acc_ff, acc_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [TB-1:0]           rsp_time_ff, rsp_time_in;

   logic [DB-1:0]           div_eff;
   logic [TOTAL_BITS-1:0]   delta_ext;
   logic [DB-1:0]           rem_shift;
   logic                    rem_ge;
   logic                    req_take;
   logic                    rsp_free;

   // effective divisor: zero reads as one, clamp at the maximum
   always_comb begin
      if (tps_ff == '0) begin
         div_eff = DB'(1);
      end else if (tps_ff > ttms_pkg::DIVISOR_MAX) begin
         div_eff = ttms_pkg::DIVISOR_MAX;
      end else begin
         div_eff = tps_ff;
      end
   end

   assign delta_ext = {{(TOTAL_BITS-COUNTER_BITS){1'b0}}, delta_ff};

   // one divider step: shift in next dividend bit, trial subtract
   assign rem_shift = {carry_ff, acc_ff[TOTAL_BITS-1]};
   assign rem_ge    = (rem_shift >= div_eff);

   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign req_stall   = (state_ff != ttms_pkg::ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_time_ms = rsp_time_ff;
   assign csr_ready   = 1'b1;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      tps_in       = tps_ff;
      elapsed_in   = elapsed_ff;
      last_in      = last_ff;
      delta_in     = delta_ff;
      carry_in     = carry_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_time_in  = rsp_time_ff;

      if (csr_valid && csr_ready) begin
         tps_in = csr_ticks_per_second;
      end

      // output register drains independently
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ttms_pkg::ST_IDLE: begin
            if (req_take) begin
               last_in = req_counter_sample;
               if (req_type == ttms_pkg::REQ_START) begin
                  elapsed_in = '0;
                  state_in   = ttms_pkg::ST_SEND;
               end else begin
                  delta_in = req_counter_sample - last_ff;
                  state_in = ttms_pkg::ST_MUL_A;
               end
            end
         end
         // delta * 1000 = (delta << 10) - (delta << 5) + (delta << 3)
         ttms_pkg::ST_MUL_A: begin
            acc_in   = (delta_ext << 10) - (delta_ext << 5);
            state_in = ttms_pkg::ST_MUL_B;
         end
         ttms_pkg::ST_MUL_B: begin
            acc_in   = acc_ff + (delta_ext << 3);
            state_in = ttms_pkg::ST_MUL_C;
         end
         // add carried remainder, then the carry register serves as divider remainder
         ttms_pkg::ST_MUL_C: begin
            acc_in   = acc_ff + {{(TOTAL_BITS-CB){1'b0}}, carry_ff};
            carry_in = '0;
            cnt_in   = '0;
            state_in = ttms_pkg::ST_DIV;
         end
         ttms_pkg::ST_DIV: begin
            if (rem_ge) begin
               carry_in = CB'(rem_shift - div_eff);
            end else begin
               carry_in = rem_shift[CB-1:0];
            end
            acc_in = {acc_ff[TOTAL_BITS-2:0], rem_ge};
            cnt_in = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(TOTAL_BITS - 1)) begin
               state_in = ttms_pkg::ST_ACC;
            end
         end
         ttms_pkg::ST_ACC: begin
            elapsed_in = elapsed_ff + {{(TB-TOTAL_BITS){1'b0}}, acc_ff};
            state_in   = ttms_pkg::ST_SEND;
         end
         ttms_pkg::ST_SEND: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_time_in  = elapsed_ff;
               state_in     = ttms_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ttms_pkg::ST_IDLE;
         end
      endcase
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ttms_pkg::ST_IDLE;
         tps_ff       <= ttms_pkg::TPS_RESET;
         elapsed_ff   <= '0;
         last_ff      <= '0;
         carry_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tps_ff       <= tps_in;
         elapsed_ff   <= elapsed_in;
         last_ff      <= last_in;
         carry_ff     <= carry_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      delta_ff    <= delta_in;
      acc_ff      <= acc_in;
      rsp_time_ff <= rsp_time_in;
   end

   // checks
   `TTMS_ASSERT_NEXT(a_update_starts_mul, req_take && req_type == ttms_pkg::REQ_UPDATE, state_ff == ttms_pkg::ST_MUL_A)
   `TTMS_ASSERT_NEXT(a_start_clears_time, req_take && req_type == ttms_pkg::REQ_START, elapsed_ff == '0)
   `TTMS_ASSERT_IMPLY(a_rem_below_div, state_ff == ttms_pkg::ST_DIV, {1'b0, carry_ff} < div_eff)
   `TTMS_ASSERT_NEXT(a_acc_to_send, state_ff == ttms_pkg::ST_ACC, state_ff == ttms_pkg::ST_SEND)

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

   localparam int CNT_BITS = ttms_pkg::COUNTER_BITS_DEFAULT;
   localparam int TM_BITS  = ttms_pkg::TIME_BITS;
   localparam int DV_BITS  = ttms_pkg::DIV_BITS;
   localparam int CY_BITS  = ttms_pkg::CARRY_BITS;

   // one request transaction
   typedef struct {
      logic                kind;
      logic [CNT_BITS-1:0] sample;
   } sample_req_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_type;
   logic [CNT_BITS-1:0]   req_counter_sample;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [TM_BITS-1:0]    rsp_time_ms;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [DV_BITS-1:0]    csr_ticks_per_second;

   tick_to_millisecond_time_base #(.COUNTER_BITS(CNT_BITS)) dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_type             (req_type),
      .req_counter_sample   (req_counter_sample),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_time_ms          (rsp_time_ms),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_ticks_per_second (csr_ticks_per_second)
   );

   // shadow of the time base state and the divisor register
   logic [TM_BITS-1:0]    ms_now;
   logic [CNT_BITS-1:0]   ref_sample;
   logic [CY_BITS-1:0]    sub_ms_carry;
   logic [DV_BITS-1:0]    tps_shadow;

   sample_req_type        pending_reqs[$];
   logic [TM_BITS-1:0]    expected_ms[$];
   int unsigned           queued_cnt;
   int unsigned           accepted_cnt;
   int unsigned           start_cnt;
   int unsigned           update_cnt;
   int unsigned           checked_cnt;
   int unsigned           tps_writes;
   int unsigned           error_cnt;
   int unsigned           req_gap;
   int unsigned           rsp_hold_left;
   bit                    quiet;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // gap length: mostly none or short, now and then long
   function automatic int unsigned draw_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // advance the shadow time base by one transaction, return the expected time
   function automatic logic [TM_BITS-1:0] advance_time_base(logic kind,
                                                            logic [CNT_BITS-1:0] sample);
      logic [DV_BITS-1:0]  divisor;
      logic [CNT_BITS-1:0] delta;
      logic [47:0]         scaled;
      if (kind == ttms_pkg::REQ_START) begin
         ms_now     = '0;
         ref_sample = sample;
      end else begin
         divisor = tps_shadow;
         if (divisor == '0) divisor = DV_BITS'(1);
         if (divisor > ttms_pkg::DIVISOR_MAX) divisor = ttms_pkg::DIVISOR_MAX;
         delta  = sample - ref_sample;
         scaled = 48'(delta) * 48'(ttms_pkg::MS_PER_SECOND) + 48'(sub_ms_carry);
         ms_now       = ms_now + 64'(scaled / 48'(divisor));
         sub_ms_carry = CY_BITS'(scaled % 48'(divisor));
         ref_sample   = sample;
      end
      return ms_now;
   endfunction

   // request driver
   always @(posedge clock) begin
      sample_req_type nxt;
      if (reset) begin
         req_valid          <= 1'b0;
         req_type           <= ttms_pkg::REQ_START;
         req_counter_sample <= '0;
         req_gap            = 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_ms.push_back(advance_time_base(req_type, req_counter_sample));
            accepted_cnt++;
            if (req_type == ttms_pkg::REQ_START) start_cnt++;
            else update_cnt++;
         end
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               nxt = pending_reqs.pop_front();
               req_valid          <= 1'b1;
               req_type           <= nxt.kind;
               req_counter_sample <= nxt.sample;
               req_gap            = quiet ? 0 : draw_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and stall generator
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall     <= 1'b0;
         rsp_hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_ms.size() == 0) begin
               $error("unexpected result transaction, time_ms %0d", rsp_time_ms);
               error_cnt++;
            end else begin
               checked_cnt++;
               if (rsp_time_ms !== expected_ms[0]) begin
                  $error("time_ms mismatch: expected %0d, actual %0d",
                         expected_ms[0], rsp_time_ms);
                  error_cnt++;
               end
               void'(expected_ms.pop_front());
            end
         end
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_hold_left = quiet ? 0 : draw_gap();
            rsp_stall <= (rsp_hold_left != 0);
         end
      end
   end

   task automatic queue_req(logic kind, logic [CNT_BITS-1:0] sample);
      sample_req_type r;
      r.kind   = kind;
      r.sample = sample;
      pending_reqs.push_back(r);
      queued_cnt++;
   endtask

   // register write, only issued while the block is idle
   task automatic set_tick_rate(logic [DV_BITS-1:0] value);
      @(posedge clock);
      csr_valid            <= 1'b1;
      csr_ticks_per_second <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      tps_shadow = value;
      tps_writes++;
   endtask

   // hold off until every queued transaction has its result back
   task automatic wait_drained();
      do @(posedge clock); while (accepted_cnt != queued_cnt || expected_ms.size() != 0);
   endtask

   // well-formed runs: a start now and then, updates with steps of mixed size
   task automatic queue_random_run(int unsigned n);
      logic [CNT_BITS-1:0] cur;
      int unsigned         r;
      cur = CNT_BITS'($urandom());
      queue_req(ttms_pkg::REQ_START, cur);
      for (int unsigned i = 1; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 8) begin
            cur = CNT_BITS'($urandom());
            queue_req(ttms_pkg::REQ_START, cur);
         end else begin
            if (r < 60) cur = cur + CNT_BITS'($urandom_range(0, 100000));
            else if (r < 80) cur = cur + CNT_BITS'($urandom_range(0, 1 << 20));
            else if (r < 90) cur = cur + CNT_BITS'($urandom_range(0, (1 << CNT_BITS) - 1));
            else cur = CNT_BITS'($urandom());
            queue_req(ttms_pkg::REQ_UPDATE, cur);
         end
      end
   endtask

   // stimulus
   initial begin
      logic [DV_BITS-1:0] rate;
      reset                = 1'b1;
      csr_valid            = 1'b0;
      csr_ticks_per_second = '0;
      ms_now               = '0;
      ref_sample           = '0;
      sub_ms_carry         = '0;
      tps_shadow           = ttms_pkg::TPS_RESET;
      queued_cnt           = 0;
      accepted_cnt         = 0;
      start_cnt            = 0;
      update_cnt           = 0;
      checked_cnt          = 0;
      tps_writes           = 0;
      error_cnt            = 0;
      quiet                = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // default rate: update before any start, zero step, wraps, largest step
      set_tick_rate(ttms_pkg::TPS_RESET);
      queue_req(ttms_pkg::REQ_UPDATE, 24'h000010);
      queue_req(ttms_pkg::REQ_UPDATE, 24'h000010);
      queue_req(ttms_pkg::REQ_START,  24'hFFFFFF);
      queue_req(ttms_pkg::REQ_UPDATE, 24'h000005);
      queue_req(ttms_pkg::REQ_UPDATE, 24'h000004);
      queue_req(ttms_pkg::REQ_START,  24'h000000);
      queue_req(ttms_pkg::REQ_UPDATE, 24'h800000);
      queue_req(ttms_pkg::REQ_START,  24'hAAAAAA);
      queue_req(ttms_pkg::REQ_UPDATE, 24'h555555);
      wait_drained();

      // one tick per second: largest product
      set_tick_rate(16'd1);
      queue_req(ttms_pkg::REQ_START,  24'h000000);
      queue_req(ttms_pkg::REQ_UPDATE, 24'hFFFFFF);
      queue_req(ttms_pkg::REQ_UPDATE, 24'hFFFFFE);
      queue_req(ttms_pkg::REQ_UPDATE, 24'h000123);
      wait_drained();

      // zero divisor acts as one
      set_tick_rate(16'd0);
      queue_req(ttms_pkg::REQ_UPDATE, 24'h000124);
      queue_req(ttms_pkg::REQ_UPDATE, 24'h000224);
      wait_drained();

      // divisors above the maximum are clamped
      set_tick_rate(16'hFFFF);
      queue_req(ttms_pkg::REQ_UPDATE, 24'h012345);
      queue_req(ttms_pkg::REQ_UPDATE, 24'h7FFFFF);
      wait_drained();
      set_tick_rate(16'd32769);
      queue_req(ttms_pkg::REQ_UPDATE, 24'h800400);
      wait_drained();

      // small divisor right after a large one: carried remainder above divisor
      set_tick_rate(16'd3);
      queue_req(ttms_pkg::REQ_UPDATE, 24'h800401);
      queue_req(ttms_pkg::REQ_UPDATE, 24'h800401);
      wait_drained();

      // random phases, each at its own divisor
      for (int p = 0; p < 8; p++) begin
         case (p % 8)
            0: rate = 16'd32768;
            1: rate = 16'd1;
            2: rate = 16'd1000;
            3: rate = 16'd32767;
            4: rate = DV_BITS'($urandom_range(0, 65535));
            5: rate = 16'd3;
            default: rate = DV_BITS'($urandom_range(1, 32768));
         endcase
         set_tick_rate(rate);
         quiet = ($urandom_range(0, 3) == 0);
         queue_random_run(106);
         wait_drained();
      end

      repeat (60) @(posedge clock);
      $display("covered %0d start and %0d update transactions over %0d divisor writes",
               start_cnt, update_cnt, tps_writes);
      $display("%0d result transactions compared", checked_cnt);
      if (error_cnt == 0 && expected_ms.size() == 0) begin
         $display("** tick_to_millisecond_time_base: PASSED **");
      end else begin
         $display("** tick_to_millisecond_time_base: FAILED **");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("** tick_to_millisecond_time_base: FAILED **");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ttms_pkg.sv
rtl/tick_to_millisecond_time_base.sv
dv/tb_top.sv
